>>> src/prq_pkg.sv
package prq_pkg;

   // Default number of queue slots
   localparam int DEPTH_DEF = 16;

   // Operation codes carried on the request tuser
   typedef enum logic [1:0] {
      FUNC_INSERT    = 2'd0,
      FUNC_PEEK      = 2'd1,
      FUNC_POP       = 2'd2,
      FUNC_SET_BURST = 2'd3
   } func_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_HEAD_CHK,
      ST_PEEK2,
      ST_DONE
   } state_type;

   // One queue slot, handle in the lowest bits
   typedef struct packed {
      logic [15:0] burst;
      logic [15:0] arrival;
      logic [7:0]  prio;
      logic [7:0]  handle;
   } entry_type;

   // Latched request
   typedef struct packed {
      func_type  func;
      entry_type ent;
   } op_type;

   // Result transaction, found in the lowest bit
   typedef struct packed {
      logic      overflow;
      logic      is_empty;
      entry_type ent;
      logic      found;
   } rsp_type;

   localparam int RSP_W   = $bits(rsp_type);
   localparam int RSP_PAD = 56 - RSP_W;

endpackage

>>> src/priority_ready_queue.sv
// Steps: pop and set-burst pass ST_HEAD_CHK and ST_DONE; peek adds ST_PEEK2 when a finished
// head is dropped; insert runs ST_INS_RD and ST_INS_CMP per queued entry that sorts behind
// the new one, then ST_INS_RD and, unless it lands at the head, ST_INS_CMP; a full queue
// skips to ST_DONE. Throughput: one transaction at a time, set by the single read port of
// the slot memory that the insert scan walks one entry at a time; the next request is taken
// the cycle after the result register loads, even while the result waits. Reset empties the queue.
module priority_ready_queue #(
   parameter int DEPTH = prq_pkg::DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: handle[7:0], prio[15:8], arrival[31:16], burst[47:32]
   input  logic [47:0] req_tdata,
   // tuser: func[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: found[0], out_handle[8:1], out_prio[16:9], out_arrival[32:17],
   //        out_burst[48:33], is_empty[49], overflow[50], zero[55:51]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   prq_pkg::entry_type mem [DEPTH];

   prq_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   prq_pkg::op_type    op_ff, op_in;
   prq_pkg::rsp_type   res_ff, res_in;
   prq_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   prq_pkg::entry_type rd_data_ff;

   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   prq_pkg::entry_type mem_wdata;

   logic               req_acc;
   logic               full;
   logic               nonempty;
   logic               out_free;
   logic               sorts_after;
   logic               drop_head;
   logic [SUM_W-1:0]   tail_sum;
   logic [IDX_W-1:0]   tail_idx;
   logic [IDX_W-1:0]   head_next;
   logic [IDX_W-1:0]   wr_prev;
   prq_pkg::func_type  req_func;

   // Decode handshake and status
   assign req_tready = (state_ff == prq_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_func   = prq_pkg::func_type'(req_tuser);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign nonempty   = (count_ff != '0);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Circular pointer arithmetic
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);
   assign head_next = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign wr_prev   = (wr_ptr_ff == '0) ? IDX_W'(DEPTH - 1) : wr_ptr_ff - 1'b1;

   // Stored entry sorts behind the new one: higher prio, or same prio and later arrival
   assign sorts_after = (rd_data_ff.prio > op_ff.ent.prio) ||
                        ((rd_data_ff.prio == op_ff.ent.prio) &&
                         (rd_data_ff.arrival > op_ff.ent.arrival));

   // Finished head to retire on peek
   assign drop_head = (op_ff.func == prq_pkg::FUNC_PEEK) && nonempty &&
                      (rd_data_ff.burst == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prq_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_func == prq_pkg::FUNC_INSERT) begin
                  state_in = full ? prq_pkg::ST_DONE : prq_pkg::ST_INS_RD;
               end else begin
                  state_in = prq_pkg::ST_HEAD_CHK;
               end
            end
         end
         prq_pkg::ST_INS_RD: begin
            state_in = (left_ff == '0) ? prq_pkg::ST_DONE : prq_pkg::ST_INS_CMP;
         end
         prq_pkg::ST_INS_CMP: begin
            state_in = sorts_after ? prq_pkg::ST_INS_RD : prq_pkg::ST_DONE;
         end
         prq_pkg::ST_HEAD_CHK: begin
            state_in = drop_head ? prq_pkg::ST_PEEK2 : prq_pkg::ST_DONE;
         end
         prq_pkg::ST_PEEK2: begin
            state_in = prq_pkg::ST_DONE;
         end
         prq_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = prq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prq_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory access
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      wr_ptr_in    = wr_ptr_ff;
      left_in      = left_ff;
      op_in        = op_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rd_addr      = head_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_ptr_ff;
      mem_wdata    = op_ff.ent;
      unique case (state_ff)
         prq_pkg::ST_IDLE: begin
            // Latch request, prepare the insert scan from the tail
            if (req_acc) begin
               op_in.func      = req_func;
               op_in.ent       = prq_pkg::entry_type'(req_tdata);
               wr_ptr_in       = tail_idx;
               left_in         = count_ff;
               res_in          = '0;
               res_in.overflow = (req_func == prq_pkg::FUNC_INSERT) && full;
               res_in.is_empty = !nonempty;
            end
         end
         prq_pkg::ST_INS_RD: begin
            // Place at the head, or fetch the entry below the write slot
            if (left_ff == '0) begin
               mem_we          = 1'b1;
               count_in        = count_ff + 1'b1;
               res_in.is_empty = 1'b0;
            end else begin
               rd_addr = wr_prev;
            end
         end
         prq_pkg::ST_INS_CMP: begin
            // Shift the stored entry up, or drop the new one in
            mem_we = 1'b1;
            if (sorts_after) begin
               mem_wdata = rd_data_ff;
               wr_ptr_in = wr_prev;
               left_in   = left_ff - 1'b1;
            end else begin
               count_in        = count_ff + 1'b1;
               res_in.is_empty = 1'b0;
            end
         end
         prq_pkg::ST_HEAD_CHK: begin
            // Fetch the following entry in case the head retires
            rd_addr = head_next;
            res_in  = '0;
            unique case (op_ff.func)
               prq_pkg::FUNC_PEEK: begin
                  if (drop_head) begin
                     head_in = head_next;
                     count_in = count_ff - 1'b1;
                  end else begin
                     res_in.found    = nonempty;
                     res_in.ent      = nonempty ? rd_data_ff : '0;
                     res_in.is_empty = !nonempty;
                  end
               end
               prq_pkg::FUNC_POP: begin
                  res_in.found    = nonempty;
                  res_in.ent      = nonempty ? rd_data_ff : '0;
                  res_in.is_empty = (count_ff <= CNT_W'(1));
                  if (nonempty) begin
                     head_in  = head_next;
                     count_in = count_ff - 1'b1;
                  end
               end
               prq_pkg::FUNC_SET_BURST: begin
                  res_in.is_empty = !nonempty;
                  if (nonempty) begin
                     mem_we              = 1'b1;
                     mem_waddr           = head_ff;
                     mem_wdata           = rd_data_ff;
                     mem_wdata.burst     = op_ff.ent.burst;
                     res_in.found        = 1'b1;
                     res_in.ent          = rd_data_ff;
                     res_in.ent.burst    = op_ff.ent.burst;
                  end
               end
               default: begin
                  res_in = res_ff;
               end
            endcase
         end
         prq_pkg::ST_PEEK2: begin
            // Report the new head after retiring the finished one
            res_in.found    = nonempty;
            res_in.ent      = nonempty ? rd_data_ff : '0;
            res_in.is_empty = !nonempty;
         end
         prq_pkg::ST_DONE: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
            end
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wr_ptr_ff <= wr_ptr_in;
      left_ff   <= left_in;
      op_ff     <= op_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{prq_pkg::RSP_PAD{1'b0}}, rsp_ff};

endmodule

>>> src/prq_checker.sv
module prq_checker (
   input logic        clock,
   input logic        reset,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // No result straight out of reset
   property p_reset_quiet;
      @(posedge clock) reset |=> !rsp_tvalid;
   endproperty
   a_reset_quiet: assert property (p_reset_quiet)
      else $error("result valid right after reset");

   // Stalled result holds
   property p_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   a_hold: assert property (p_hold)
      else $error("stalled result changed");

   // Nothing reported means zero head fields
   property p_zero_fields;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tdata[0] |-> (rsp_tdata[48:1] == 48'd0);
   endproperty
   a_zero_fields: assert property (p_zero_fields)
      else $error("head fields set without found");

   // A dropped insert means the queue is full, never empty, and reports no head
   property p_overflow;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && rsp_tdata[50] |-> !rsp_tdata[49] && !rsp_tdata[0];
   endproperty
   a_overflow: assert property (p_overflow)
      else $error("overflow with empty queue or reported head");

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
